@@ src/i2c_rts_pkg.sv @@
// Package for the I2C register transaction sequencer.
// It holds the word types, function, command, phase, bus action and status codes.
// It has no dependencies; the core and the top level both use it.
package i2c_rts_pkg;

  localparam logic [1:0] FUNC_STEP  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [3:0] PH_DEV     = 4'd0;
  localparam logic [3:0] PH_REG     = 4'd1;
  localparam logic [3:0] PH_RESTART = 4'd2;
  localparam logic [3:0] PH_RDREQ   = 4'd3;
  localparam logic [3:0] PH_RDTAKE  = 4'd4;
  localparam logic [3:0] PH_WAIT    = 4'd5;
  localparam logic [3:0] PH_RECOVER = 4'd6;
  localparam logic [3:0] PH_DATA    = 4'd7;
  localparam logic [3:0] PH_STOP    = 4'd8;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_RESTART = 3'd2;
  localparam logic [2:0] ACT_SEND    = 3'd3;
  localparam logic [2:0] ACT_RDACK   = 3'd4;
  localparam logic [2:0] ACT_RDNACK  = 3'd5;
  localparam logic [2:0] ACT_STOP    = 3'd6;
  localparam logic [2:0] ACT_RECOVER = 3'd7;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_READING = 3'd1;
  localparam logic [2:0] ST_WRITING = 3'd2;
  localparam logic [2:0] ST_RDONE   = 3'd3;
  localparam logic [2:0] ST_WDONE   = 3'd4;

  localparam logic [7:0] READ_BIT = 8'h01;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       xfer_done;
    logic       arb_lost;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       clear_done;
    logic [2:0] status;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_data;
    logic       last;
  } out_word_t;

endpackage

@@ src/i2c_register_transaction_sequencer_top.sv @@
// I2C register transaction sequencer: input word register, result register
// and the sequencer core. Depends on i2c_rts_pkg and i2c_rts_core.
//
// Usage: each input word is either a register read or write request
// (func 1 or 2) or a step (func 0) carrying the bus engine's sampled flags.
// Every accepted word yields exactly one result word: the bus action to
// issue, the byte to send, the done-flag clear, the status, any delivered
// received byte and a flag marking the end of the transaction.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. An accepted word is held in the input register until the
// result register has room; the core evaluates it combinationally and the
// result register then loads the result.
// One word can be accepted every cycle while the receiver does not stall,
// as the core updates its state on each advance.
// While the receiver stalls, the pending result holds and one more word
// may still be taken into the input register; further words are stalled.
// Reset clears the sequencer to idle with no pending words.
module i2c_register_transaction_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] dev_addr_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] byte_count_i,
  input  logic [7:0] write_data_i,
  input  logic       xfer_done_i,
  input  logic       arb_lost_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] bus_action_o,
  output logic [7:0] tx_byte_o,
  output logic       clear_done_o,
  output logic [2:0] status_o,
  output logic       rx_valid_o,
  output logic [7:0] rx_index_o,
  output logic [7:0] rx_data_o,
  output logic       last_o
);

  logic                   in_v_q;
  i2c_rts_pkg::in_word_t  in_word_q;
  logic                   out_v_q;
  i2c_rts_pkg::out_word_t out_word_q;
  i2c_rts_pkg::out_word_t core_res;
  logic                   out_free;
  logic                   adv;
  logic                   in_acc;

  assign out_free   = !out_v_q || !out_stall_i;
  assign adv        = in_v_q && out_free;
  assign in_stall_o = in_v_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_acc || adv) begin
      in_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_word_q.func       <= func_i;
      in_word_q.dev_addr   <= dev_addr_i;
      in_word_q.reg_addr   <= reg_addr_i;
      in_word_q.byte_count <= byte_count_i;
      in_word_q.write_data <= write_data_i;
      in_word_q.xfer_done  <= xfer_done_i;
      in_word_q.arb_lost   <= arb_lost_i;
      in_word_q.rx_byte    <= rx_byte_i;
    end
  end

  i2c_rts_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .word_i (in_word_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q <= core_res;
    end
  end

  assign out_valid_o  = out_v_q;
  assign bus_action_o = out_word_q.bus_action;
  assign tx_byte_o    = out_word_q.tx_byte;
  assign clear_done_o = out_word_q.clear_done;
  assign status_o     = out_word_q.status;
  assign rx_valid_o   = out_word_q.rx_valid;
  assign rx_index_o   = out_word_q.rx_index;
  assign rx_data_o    = out_word_q.rx_data;
  assign last_o       = out_word_q.last;

  // A done-flag clear never coincides with a new bus action.
  a_clear_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_word_q.clear_done) |-> (out_word_q.bus_action == i2c_rts_pkg::ACT_NONE))
    else $error("clear_done issued together with a bus action");

  // The end of a transaction is always a stop with a completion status.
  a_last_stop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_word_q.last) |->
      ((out_word_q.bus_action == i2c_rts_pkg::ACT_STOP) &&
       ((out_word_q.status == i2c_rts_pkg::ST_RDONE) ||
        (out_word_q.status == i2c_rts_pkg::ST_WDONE))))
    else $error("transaction end without stop or completion status");

  // A delivered byte belongs to a read.
  a_rx_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_word_q.rx_valid) |->
      ((out_word_q.status == i2c_rts_pkg::ST_READING) ||
       (out_word_q.status == i2c_rts_pkg::ST_RDONE)))
    else $error("received byte delivered outside a read");

  // The input register only moves on when the result register has room.
  a_adv_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && out_v_q && out_stall_i) |=> (in_v_q && $stable(in_word_q)))
    else $error("input word lost while result register full");

endmodule

@@ src/i2c_rts_core.sv @@
// Sequencer core: transaction state registers and the single-step logic.
// It turns one registered input word into one result word per advance.
// Depends on i2c_rts_pkg.
module i2c_rts_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  i2c_rts_pkg::in_word_t word_i,
  output i2c_rts_pkg::out_word_t res_o
);

  logic [1:0] cmd_q, cmd_d;
  logic [3:0] phase_q, phase_d;
  logic [3:0] paw_q, paw_d;
  logic [3:0] retry_q, retry_d;
  logic [7:0] bytes_q, bytes_d;
  logic       lrf_q, lrf_d;
  logic [7:0] dev_q, dev_d;
  logic [7:0] reg_q, reg_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] wbyte_q, wbyte_d;
  logic [2:0] status_q, status_d;
  logic       rd;
  logic       is_req;
  logic       last_rd;

  assign rd      = (cmd_q == i2c_rts_pkg::CMD_READ);
  assign is_req  = (word_i.func == i2c_rts_pkg::FUNC_READ) ||
                   (word_i.func == i2c_rts_pkg::FUNC_WRITE);
  assign last_rd = ({1'b0, bytes_q} + 9'd1) >= {1'b0, cnt_q};

  always_comb begin
    cmd_d    = cmd_q;
    phase_d  = phase_q;
    paw_d    = paw_q;
    retry_d  = retry_q;
    bytes_d  = bytes_q;
    lrf_d    = lrf_q;
    dev_d    = dev_q;
    reg_d    = reg_q;
    cnt_d    = cnt_q;
    wbyte_d  = wbyte_q;
    status_d = status_q;
    res_o    = '0;

    if (is_req) begin
      // A request while a transaction is running is dropped.
      if (cmd_q == i2c_rts_pkg::CMD_NONE) begin
        dev_d   = word_i.dev_addr;
        reg_d   = word_i.reg_addr;
        cnt_d   = (word_i.byte_count == 8'd0) ? 8'd1 : word_i.byte_count;
        wbyte_d = word_i.write_data;
        if (word_i.func == i2c_rts_pkg::FUNC_READ) begin
          cmd_d    = i2c_rts_pkg::CMD_READ;
          status_d = i2c_rts_pkg::ST_READING;
        end else begin
          cmd_d    = i2c_rts_pkg::CMD_WRITE;
          status_d = i2c_rts_pkg::ST_WRITING;
        end
        phase_d = i2c_rts_pkg::PH_DEV;
        bytes_d = 8'd0;
      end
    end else if (cmd_q == i2c_rts_pkg::CMD_NONE) begin
      status_d = i2c_rts_pkg::ST_IDLE;
    end else begin
      unique case (phase_q)
        i2c_rts_pkg::PH_DEV: begin
          status_d = rd ? i2c_rts_pkg::ST_READING : i2c_rts_pkg::ST_WRITING;
          bytes_d  = 8'd0;
          res_o.bus_action = i2c_rts_pkg::ACT_START;
          res_o.tx_byte    = dev_q;
          if (word_i.arb_lost) begin
            retry_d = i2c_rts_pkg::PH_DEV;
            phase_d = i2c_rts_pkg::PH_RECOVER;
          end else begin
            paw_d   = i2c_rts_pkg::PH_REG;
            phase_d = i2c_rts_pkg::PH_WAIT;
          end
        end
        i2c_rts_pkg::PH_REG: begin
          res_o.bus_action = i2c_rts_pkg::ACT_SEND;
          res_o.tx_byte    = reg_q;
          if (word_i.arb_lost) begin
            retry_d = i2c_rts_pkg::PH_REG;
            phase_d = i2c_rts_pkg::PH_RECOVER;
          end else begin
            paw_d   = rd ? i2c_rts_pkg::PH_RESTART : i2c_rts_pkg::PH_DATA;
            phase_d = i2c_rts_pkg::PH_WAIT;
          end
        end
        i2c_rts_pkg::PH_RESTART: begin
          if (!rd) begin
            phase_d = i2c_rts_pkg::PH_DEV;
          end else begin
            res_o.bus_action = i2c_rts_pkg::ACT_RESTART;
            res_o.tx_byte    = dev_q | i2c_rts_pkg::READ_BIT;
            if (word_i.arb_lost) begin
              retry_d = i2c_rts_pkg::PH_RESTART;
              phase_d = i2c_rts_pkg::PH_RECOVER;
            end else begin
              paw_d   = i2c_rts_pkg::PH_RDREQ;
              phase_d = i2c_rts_pkg::PH_WAIT;
            end
          end
        end
        i2c_rts_pkg::PH_RDREQ: begin
          if (!rd) begin
            phase_d = i2c_rts_pkg::PH_DEV;
          end else begin
            lrf_d = last_rd;
            res_o.bus_action = last_rd ? i2c_rts_pkg::ACT_RDNACK : i2c_rts_pkg::ACT_RDACK;
            paw_d   = i2c_rts_pkg::PH_RDTAKE;
            phase_d = i2c_rts_pkg::PH_WAIT;
          end
        end
        i2c_rts_pkg::PH_RDTAKE: begin
          if (!rd) begin
            phase_d = i2c_rts_pkg::PH_DEV;
          end else begin
            res_o.rx_valid = 1'b1;
            res_o.rx_index = bytes_q;
            res_o.rx_data  = word_i.rx_byte;
            bytes_d        = bytes_q + 8'd1;
            if (lrf_q) begin
              res_o.bus_action = i2c_rts_pkg::ACT_STOP;
              res_o.last       = 1'b1;
              status_d         = i2c_rts_pkg::ST_RDONE;
              cmd_d            = i2c_rts_pkg::CMD_NONE;
              phase_d          = i2c_rts_pkg::PH_DEV;
            end else begin
              phase_d = i2c_rts_pkg::PH_RDREQ;
            end
          end
        end
        i2c_rts_pkg::PH_WAIT: begin
          if (word_i.xfer_done) begin
            res_o.clear_done = 1'b1;
            phase_d          = paw_q;
          end
        end
        i2c_rts_pkg::PH_RECOVER: begin
          res_o.bus_action = i2c_rts_pkg::ACT_RECOVER;
          phase_d          = retry_q;
        end
        i2c_rts_pkg::PH_DATA: begin
          if (rd) begin
            phase_d = i2c_rts_pkg::PH_DEV;
          end else begin
            res_o.bus_action = i2c_rts_pkg::ACT_SEND;
            res_o.tx_byte    = wbyte_q;
            paw_d            = i2c_rts_pkg::PH_STOP;
            phase_d          = i2c_rts_pkg::PH_WAIT;
          end
        end
        i2c_rts_pkg::PH_STOP: begin
          if (rd) begin
            phase_d = i2c_rts_pkg::PH_DEV;
          end else begin
            res_o.bus_action = i2c_rts_pkg::ACT_STOP;
            res_o.last       = 1'b1;
            status_d         = i2c_rts_pkg::ST_WDONE;
            cmd_d            = i2c_rts_pkg::CMD_NONE;
            phase_d          = i2c_rts_pkg::PH_DEV;
          end
        end
        default: begin
          phase_d = i2c_rts_pkg::PH_DEV;
        end
      endcase
    end

    res_o.status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= i2c_rts_pkg::CMD_NONE;
      phase_q  <= i2c_rts_pkg::PH_DEV;
      paw_q    <= i2c_rts_pkg::PH_DEV;
      retry_q  <= i2c_rts_pkg::PH_DEV;
      bytes_q  <= 8'd0;
      lrf_q    <= 1'b0;
      dev_q    <= 8'd0;
      reg_q    <= 8'd0;
      cnt_q    <= 8'd0;
      wbyte_q  <= 8'd0;
      status_q <= i2c_rts_pkg::ST_IDLE;
    end else if (adv_i) begin
      cmd_q    <= cmd_d;
      phase_q  <= phase_d;
      paw_q    <= paw_d;
      retry_q  <= retry_d;
      bytes_q  <= bytes_d;
      lrf_q    <= lrf_d;
      dev_q    <= dev_d;
      reg_q    <= reg_d;
      cnt_q    <= cnt_d;
      wbyte_q  <= wbyte_d;
      status_q <= status_d;
    end
  end

endmodule
